/* rtl/core/circular_byte_fifo_unit_macros.svh */
// Assertion macros used by the checker module.
`ifndef CIRCULAR_BYTE_FIFO_UNIT_MACROS_SVH
`define CIRCULAR_BYTE_FIFO_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define CBF_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("circular byte fifo check failed");

// Condition in one cycle requires a property in the next cycle.
`define CBF_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("circular byte fifo check failed");

`endif

/* rtl/core/cbf_pkg.sv */
package cbf_pkg;

  localparam int DEPTH   = 64;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 6;

  localparam logic [FIELD_W-1:0] MAX_IDX   = FIELD_W'(DEPTH - 1);
  localparam logic [FIELD_W-1:0] WRAP_RST  = 6'd63;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } cbf_mem_req_t;

endpackage

/* rtl/core/circular_byte_fifo_unit.sv */
// A push's beat appears on the result ports in the next cycle.
// A pop of n bytes sends one beat per cycle, each in the cycle after its read, and a
// pop of none sends a single beat; the single read port of the byte memory sets this
// rate of one byte a cycle. busy is high while the last n-1 bytes of a burst are read; results cannot stall.
// Reset is synchronous: pointers, count and overflow clear and wrap_point returns to 63.
// The byte memory is not cleared.
module circular_byte_fifo_unit
  import cbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [BYTE_W-1:0]  in_push_byte,
  input  logic [FIELD_W-1:0] in_pop_count,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  output logic               out_strobe,
  output logic [BYTE_W-1:0]  out_read_byte,
  output logic               out_byte_valid,
  output logic               out_push_accepted,
  output logic               out_last,
  output logic [FIELD_W-1:0] out_bytes_queued,
  output logic [FIELD_W-1:0] out_bytes_free,
  output logic               out_overflow
);

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  state_t             state_r, state_nxt;
  logic [FIELD_W-1:0] wrap_r, wrap_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [PTR_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   rem_r, rem_nxt;
  logic               ovf_r, ovf_nxt;

  logic               strobe_r, strobe_nxt;
  logic               bvalid_r, bvalid_nxt;
  logic               accepted_r, accepted_nxt;
  logic               last_r, last_nxt;
  logic [PTR_W-1:0]   queued_r, queued_nxt;
  logic [PTR_W-1:0]   free_r, free_nxt;

  logic [FIELD_W-1:0] eff_w6;
  logic [PTR_W-1:0]   eff_w;
  logic [PTR_W-1:0]   step_in;
  logic [PTR_W-1:0]   step_out;
  logic [FIELD_W-1:0] cnt6;
  logic [FIELD_W-1:0] n6;
  logic [PTR_W-1:0]   n;
  logic [PTR_W-1:0]   count_dec;
  logic               accept;
  cbf_mem_req_t       mem_req;
  logic [BYTE_W-1:0]  rd_data;

  assign eff_w6    = (wrap_r > MAX_IDX) ? MAX_IDX : wrap_r;
  assign eff_w     = eff_w6[PTR_W-1:0];
  assign accept    = start && (state_r == ST_IDLE);
  assign cnt6      = FIELD_W'(count_r);
  assign n6        = (in_pop_count < cnt6) ? in_pop_count : cnt6;
  assign n         = n6[PTR_W-1:0];
  assign count_dec = count_r - PTR_W'(1);

  // Shared pointer stepper with wrap.
  assign step_in  = (state_r == ST_IDLE && in_command == CMD_PUSH) ? wp_r : rp_r;
  assign step_out = (step_in == eff_w) ? '0 : step_in + PTR_W'(1);

  always_comb begin
    state_nxt    = state_r;
    wrap_nxt     = wrap_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    count_nxt    = count_r;
    rem_nxt      = rem_r;
    ovf_nxt      = ovf_r;
    strobe_nxt   = 1'b0;
    bvalid_nxt   = 1'b0;
    accepted_nxt = 1'b0;
    last_nxt     = 1'b1;
    queued_nxt   = count_r;
    free_nxt     = eff_w - count_r;
    mem_req      = '0;
    mem_req.waddr = wp_r;
    mem_req.wdata = in_push_byte;
    mem_req.raddr = rp_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          wrap_nxt  = cfg_wdata;
          wp_nxt    = '0;
          rp_nxt    = '0;
          count_nxt = '0;
        end else if (accept) begin
          strobe_nxt = 1'b1;
          if (in_command == CMD_PUSH) begin
            if (count_r == eff_w) begin
              ovf_nxt = 1'b1;
            end else begin
              mem_req.we   = 1'b1;
              wp_nxt       = step_out;
              count_nxt    = count_r + PTR_W'(1);
              accepted_nxt = 1'b1;
              queued_nxt   = count_r + PTR_W'(1);
              free_nxt     = eff_w - (count_r + PTR_W'(1));
            end
          end else if (n != '0) begin
            mem_req.re = 1'b1;
            rp_nxt     = step_out;
            count_nxt  = count_dec;
            bvalid_nxt = 1'b1;
            last_nxt   = (n == PTR_W'(1));
            queued_nxt = count_dec;
            free_nxt   = eff_w - count_dec;
            rem_nxt    = n - PTR_W'(1);
            if (n != PTR_W'(1)) begin
              state_nxt = ST_POP;
            end
          end
        end
      end
      ST_POP: begin
        mem_req.re = 1'b1;
        rp_nxt     = step_out;
        count_nxt  = count_dec;
        rem_nxt    = rem_r - PTR_W'(1);
        strobe_nxt = 1'b1;
        bvalid_nxt = 1'b1;
        last_nxt   = (rem_r == PTR_W'(1));
        queued_nxt = count_dec;
        free_nxt   = eff_w - count_dec;
        if (rem_r == PTR_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wrap_r     <= WRAP_RST;
      wp_r       <= '0;
      rp_r       <= '0;
      count_r    <= '0;
      rem_r      <= '0;
      ovf_r      <= 1'b0;
      strobe_r   <= 1'b0;
      bvalid_r   <= 1'b0;
      accepted_r <= 1'b0;
      last_r     <= 1'b0;
      queued_r   <= '0;
      free_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      wrap_r     <= wrap_nxt;
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      count_r    <= count_nxt;
      rem_r      <= rem_nxt;
      ovf_r      <= ovf_nxt;
      strobe_r   <= strobe_nxt;
      bvalid_r   <= bvalid_nxt;
      accepted_r <= accepted_nxt;
      last_r     <= last_nxt;
      queued_r   <= queued_nxt;
      free_r     <= free_nxt;
    end
  end

  cbf_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = strobe_r;
  assign out_byte_valid    = bvalid_r;
  assign out_read_byte     = bvalid_r ? rd_data : '0;
  assign out_push_accepted = accepted_r;
  assign out_last          = last_r;
  assign out_bytes_queued  = FIELD_W'(queued_r);
  assign out_bytes_free    = FIELD_W'(free_r);
  assign out_overflow      = ovf_r;

endmodule

/* rtl/core/cbf_store.sv */
module cbf_store
  import cbf_pkg::*;
(
  input  logic              clk,
  input  cbf_mem_req_t      req,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

/* rtl/core/cbf_checker.sv */
`include "circular_byte_fifo_unit_macros.svh"

module cbf_checker
  import cbf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_command,
  input logic               out_strobe,
  input logic               out_byte_valid,
  input logic               out_last,
  input logic [FIELD_W-1:0] out_bytes_queued
);

  `CBF_ASSERT_NEXT(a_accept_gives_beat, start && !busy, out_strobe)
  `CBF_ASSERT_NEXT(a_push_single_beat, start && !busy && in_command == CMD_PUSH,
    out_last && !out_byte_valid)
  `CBF_ASSERT_NEXT(a_burst_no_gap, out_strobe && !out_last, out_strobe && out_byte_valid)
  `CBF_ASSERT_IMPL(a_burst_drains, out_strobe && $past(out_strobe) && !$past(out_last),
    out_bytes_queued == $past(out_bytes_queued) - 6'd1)
  `CBF_ASSERT_IMPL(a_busy_after_accept, $rose(busy), $past(start))

endmodule

bind circular_byte_fifo_unit cbf_checker u_cbf_checker (.*);

/* tb/sv/tb_circular_byte_fifo_unit.sv */
module tb_circular_byte_fifo_unit;
  import cbf_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               byte_valid;
    logic               push_accepted;
    logic               last;
    logic [FIELD_W-1:0] bytes_queued;
    logic [FIELD_W-1:0] bytes_free;
    logic               overflow;
  } fifo_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_command = CMD_PUSH;
  logic [BYTE_W-1:0]  in_push_byte = '0;
  logic [FIELD_W-1:0] in_pop_count = '0;
  logic               cfg_we = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata = '0;
  logic               out_strobe;
  logic [BYTE_W-1:0]  out_read_byte;
  logic               out_byte_valid;
  logic               out_push_accepted;
  logic               out_last;
  logic [FIELD_W-1:0] out_bytes_queued;
  logic [FIELD_W-1:0] out_bytes_free;
  logic               out_overflow;

  logic [BYTE_W-1:0] ring_mem [DEPTH];
  int unsigned       ring_wr;
  int unsigned       ring_rd;
  int unsigned       ring_wrap;
  logic              ring_ovf;
  fifo_beat_t        fifo_beats_due[$];

  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned pushes_sent;
  int unsigned pops_sent;
  int unsigned wraps_written;
  int unsigned quiet_cycles;

  always #1 clk = ~clk;

  circular_byte_fifo_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_push_byte      (in_push_byte),
    .in_pop_count      (in_pop_count),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_read_byte     (out_read_byte),
    .out_byte_valid    (out_byte_valid),
    .out_push_accepted (out_push_accepted),
    .out_last          (out_last),
    .out_bytes_queued  (out_bytes_queued),
    .out_bytes_free    (out_bytes_free),
    .out_overflow      (out_overflow)
  );

  function automatic int unsigned ring_fill();
    if (ring_wr >= ring_rd) begin
      return ring_wr - ring_rd;
    end
    return ((ring_wrap - ring_rd) + ring_wr + 1) & 63;
  endfunction

  function automatic void queue_status_beat(logic [BYTE_W-1:0] rbyte, logic valid,
                                            logic accepted, logic is_last);
    fifo_beat_t  b;
    int unsigned q;
    q = ring_fill();
    b.read_byte     = rbyte;
    b.byte_valid    = valid;
    b.push_accepted = accepted;
    b.last          = is_last;
    b.bytes_queued  = FIELD_W'(q);
    b.bytes_free    = (ring_wrap >= q) ? FIELD_W'(ring_wrap - q) : '0;
    b.overflow      = ring_ovf;
    fifo_beats_due.push_back(b);
  endfunction

  function automatic void advance_ring(logic cmd, logic [BYTE_W-1:0] data,
                                       logic [FIELD_W-1:0] count);
    int unsigned       nxt;
    int unsigned       n;
    logic [BYTE_W-1:0] rbyte;
    if (cmd == CMD_PUSH) begin
      nxt = ring_wr + 1;
      if (nxt > ring_wrap) begin
        nxt = 0;
      end
      if (nxt != ring_rd) begin
        ring_mem[PTR_W'(ring_wr)] = data;
        ring_wr = nxt;
        queue_status_beat('0, 1'b0, 1'b1, 1'b1);
      end else begin
        ring_ovf = 1'b1;
        queue_status_beat('0, 1'b0, 1'b0, 1'b1);
      end
    end else begin
      n = ring_fill();
      if (32'(count) < n) begin
        n = 32'(count);
      end
      if (n == 0) begin
        queue_status_beat('0, 1'b0, 1'b0, 1'b1);
      end
      for (int unsigned i = 0; i < n; i++) begin
        rbyte = ring_mem[PTR_W'(ring_rd)];
        ring_rd = (ring_rd >= ring_wrap) ? 0 : ring_rd + 1;
        queue_status_beat(rbyte, 1'b1, 1'b0, (i + 1 == n));
      end
    end
  endfunction

  function automatic void flag_mismatch(string what, fifo_beat_t got, fifo_beat_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected byte=%h valid=%b acc=%b last=%b queued=%0d free=%0d ovf=%b",
               what, want.read_byte, want.byte_valid, want.push_accepted, want.last,
               want.bytes_queued, want.bytes_free, want.overflow);
      $display("    actual byte=%h valid=%b acc=%b last=%b queued=%0d free=%0d ovf=%b",
               got.read_byte, got.byte_valid, got.push_accepted, got.last,
               got.bytes_queued, got.bytes_free, got.overflow);
    end
  endfunction

  always @(posedge clk) begin : check_beats
    fifo_beat_t seen;
    fifo_beat_t want;
    if (rst_n && out_strobe) begin
      seen = {out_read_byte, out_byte_valid, out_push_accepted, out_last,
              out_bytes_queued, out_bytes_free, out_overflow};
      if (fifo_beats_due.size() == 0) begin
        flag_mismatch("beat with nothing pending", seen, '0);
      end else begin
        want = fifo_beats_due.pop_front();
        beats_checked++;
        if (seen !== want) begin
          flag_mismatch("field differs", seen, want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic cmd, logic [BYTE_W-1:0] data, logic [FIELD_W-1:0] count);
    @(negedge clk);
    start        <= 1'b1;
    in_command   <= cmd;
    in_push_byte <= data;
    in_pop_count <= count;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    advance_ring(cmd, data, count);
    if (cmd == CMD_PUSH) begin
      pushes_sent++;
    end else begin
      pops_sent++;
    end
  endtask

  task automatic idle_cycles(int unsigned n);
    @(negedge clk);
    start        <= 1'b0;
    in_command   <= 1'($urandom_range(0, 1));
    in_push_byte <= BYTE_W'($urandom_range(0, 255));
    in_pop_count <= FIELD_W'($urandom_range(0, 63));
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (fifo_beats_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // The write empties the ring but keeps the overflow flag.
  task automatic write_wrap_point(logic [FIELD_W-1:0] value);
    wait_drained();
    @(negedge clk);
    start     <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    ring_wrap = 32'(value);
    ring_wr   = 0;
    ring_rd   = 0;
    wraps_written++;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= FIELD_W'($urandom_range(0, 63));
  endtask

  function automatic logic [FIELD_W-1:0] pick_pop_count();
    case ($urandom_range(0, 15))
      0, 1:    return '0;
      2:       return 6'd63;
      3, 4, 5: return FIELD_W'($urandom_range(0, 63));
      default: return FIELD_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic test_basic_push_pop();
    send_item(CMD_POP, 8'h00, 6'd5);
    send_item(CMD_PUSH, 8'h00, 6'd0);
    send_item(CMD_PUSH, 8'hFF, 6'd63);
    send_item(CMD_PUSH, 8'hA5, 6'd21);
    send_item(CMD_PUSH, 8'h5A, 6'd42);
    send_item(CMD_POP, 8'hFF, 6'd0);
    send_item(CMD_POP, 8'h00, 6'd1);
    send_item(CMD_POP, 8'h00, 6'd63);
    send_item(CMD_POP, 8'h00, 6'd63);
  endtask

  task automatic test_full_and_overflow();
    write_wrap_point(6'd1);
    send_item(CMD_PUSH, 8'hAA, 6'd0);
    send_item(CMD_PUSH, 8'h55, 6'd0);
    send_item(CMD_POP, 8'h00, 6'd63);
    send_item(CMD_POP, 8'h00, 6'd1);
    write_wrap_point(6'd3);
    for (int i = 0; i < 4; i++) begin
      send_item(CMD_PUSH, 8'(8'h10 + i), 6'd0);
    end
    send_item(CMD_POP, 8'h00, 6'd2);
    send_item(CMD_PUSH, 8'hC3, 6'd0);
    send_item(CMD_PUSH, 8'h3C, 6'd0);
    send_item(CMD_POP, 8'h00, 6'd63);
  endtask

  task automatic test_fill_largest_ring();
    write_wrap_point(6'd63);
    repeat (66) begin
      if ($urandom_range(0, 5) == 0) begin
        idle_cycles($urandom_range(1, 5));
      end
      send_item(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), FIELD_W'($urandom_range(0, 63)));
    end
    while (ring_fill() != 0) begin
      if ($urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 5));
      end
      send_item(CMD_POP, BYTE_W'($urandom_range(0, 255)), FIELD_W'($urandom_range(1, 63)));
    end
  endtask

  task automatic test_random_traffic(logic [FIELD_W-1:0] wrap, int unsigned items,
                                     int unsigned push_pct, bit with_gaps);
    logic cmd;
    write_wrap_point(wrap);
    repeat (items) begin
      if (with_gaps && $urandom_range(0, 5) == 0) begin
        idle_cycles($urandom_range(1, 5));
      end
      cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
      send_item(cmd, BYTE_W'($urandom_range(0, 255)), pick_pop_count());
    end
  endtask

  initial begin
    ring_wr   = 0;
    ring_rd   = 0;
    ring_wrap = 32'(WRAP_RST);
    ring_ovf  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_push_pop();
    test_full_and_overflow();
    test_fill_largest_ring();
    test_random_traffic(6'd1, 40, 60, 1'b1);
    test_random_traffic(FIELD_W'($urandom_range(2, 62)), 60, 70, 1'b1);
    test_random_traffic(6'd6, 40, 65, 1'b1);
    test_random_traffic(6'd63, 50, 70, 1'b0);

    idle_cycles(1);
    wait_drained();
    repeat (4) @(posedge clk);
    if (fifo_beats_due.size() != 0) begin
      mismatches += fifo_beats_due.size();
      $display("%0d expected beats never arrived", fifo_beats_due.size());
    end
    $display("Sent %0d pushes and %0d pops over %0d wrap point settings (1 to 63).",
             pushes_sent, pops_sent, wraps_written);
    $display("Checked %0d result beats, including full, empty and zero-count pops.",
             beats_checked);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cbf_pkg.sv
rtl/core/cbf_store.sv
rtl/core/circular_byte_fifo_unit.sv
rtl/core/cbf_checker.sv
tb/sv/tb_circular_byte_fifo_unit.sv
